// ----- hw/rtl/positional_list_engine_unit_defines.svh -----
// assertion macros shared by the positional list engine rtl
// no dependencies; taken in by `include where assertions are written
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTH

// check held on every clock edge outside reset
`define PLE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ple assertion failed");

// check that also holds while reset is applied
`define PLE_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("ple assertion failed");

`else

`define PLE_ASSERT(lbl, clk, rst, prop)
`define PLE_ASSERT_RST(lbl, clk, prop)

`endif

`endif

// ----- hw/rtl/ple_pkg.sv -----
// types, sizes and codes of the positional list engine
// no dependencies; used by ple_cell, ple_ctrl and positional_list_engine_unit
package ple_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (LEN_W + 1 > 5) ? LEN_W + 1 : 5;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [LEN_W-1:0]      len_t;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic del;
    idx_t idx;
  } cmd_t;

endpackage

// ----- hw/rtl/positional_list_engine_unit.sv -----
// top level of the positional list engine: control plus a chain of storage cells
// depends on ple_pkg, ple_cell and ple_ctrl
//
// channel   direction  handshake           payload
// request   in         start, busy         kind, position, data_in
// result    out        done (one cycle)    status, data_out, count
//
// every request is decoded when accepted, and the cell chain shifts up
// (insert) or down (delete) in the same clock edge that accepts it
// the result appears on the cycle after acceptance, marked by done for one cycle
// busy stays low, so a new request may be given on every cycle
// rst is synchronous and empties the list; cell contents are not cleared
// the receiver cannot stall, results are never held back
module positional_list_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  kind,
  input  logic [4:0]  position,
  input  logic [31:0] data_in,
  output logic        busy,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] data_out,
  output logic [4:0]  count
);

  ple_pkg::cmd_t  cmd;
  ple_pkg::word_t cells_q [ple_pkg::DEPTH];
  ple_pkg::word_t left_w  [ple_pkg::DEPTH];
  ple_pkg::word_t right_w [ple_pkg::DEPTH];
  ple_pkg::word_t word_in;

  // one request per cycle, never held off
  assign busy = 1'b0;

  // stored word is sized to the entry width, which equals the 32-bit data_in
  assign word_in = ple_pkg::DATA_WIDTH'(data_in);

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .kind     (kind),
    .position (position),
    .cells_q  (cells_q),
    .cmd      (cmd),
    .done     (done),
    .status   (status),
    .data_out (data_out),
    .count    (count)
  );

  // chain of cells: position p lives in cell p-1, neighbours feed each other
  for (genvar g = 0; g < ple_pkg::DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = '0;
    end else begin : g_mid_l
      assign left_w[g] = cells_q[g-1];
    end

    if (g == ple_pkg::DEPTH - 1) begin : g_last
      assign right_w[g] = '0;
    end else begin : g_mid_r
      assign right_w[g] = cells_q[g+1];
    end

    ple_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cell_index (ple_pkg::IDX_W'(g)),
      .data_in    (word_in),
      .left_q     (left_w[g]),
      .right_q    (right_w[g]),
      .q          (cells_q[g])
    );
  end

endmodule

// ----- hw/rtl/ple_cell.sv -----
// one storage cell of the list chain: holds one entry
// depends on ple_pkg
module ple_cell (
  input  logic            clk,
  input  ple_pkg::cmd_t   cmd,
  input  ple_pkg::idx_t   cell_index,
  input  ple_pkg::word_t  data_in,
  input  ple_pkg::word_t  left_q,
  input  ple_pkg::word_t  right_q,
  output ple_pkg::word_t  q
);

  ple_pkg::word_t q_next;

  always_comb begin
    q_next = q;
    if (cmd.ins) begin
      if (cell_index == cmd.idx) begin
        q_next = data_in;
      end else if (cell_index > cmd.idx) begin
        q_next = left_q;
      end
    end else if (cmd.del) begin
      if (cell_index >= cmd.idx) begin
        q_next = right_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ----- hw/rtl/ple_ctrl.sv -----
// request decode, length count, status and result registers
// depends on ple_pkg and positional_list_engine_unit_defines.svh
`include "positional_list_engine_unit_defines.svh"

module ple_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      kind,
  input  logic [4:0]      position,
  input  ple_pkg::word_t  cells_q [ple_pkg::DEPTH],
  output ple_pkg::cmd_t   cmd,
  output logic            done,
  output logic [1:0]      status,
  output logic [31:0]     data_out,
  output logic [4:0]      count
);

  ple_pkg::len_t              length;
  ple_pkg::len_t              length_next;
  ple_pkg::status_t           st;
  ple_pkg::status_t           status_q;
  logic                       ins_ok;
  logic                       del_ok;
  logic                       rd_ok;
  logic [ple_pkg::CMP_W-1:0]  pos_ext;
  logic [ple_pkg::CMP_W-1:0]  len_ext;
  ple_pkg::idx_t              idx;
  ple_pkg::word_t             rd_word;

  assign pos_ext = ple_pkg::CMP_W'(position);
  assign len_ext = ple_pkg::CMP_W'(length);
  assign idx     = ple_pkg::IDX_W'(pos_ext - ple_pkg::CMP_W'(1));

  always_comb begin
    st     = ple_pkg::ST_BADPOS;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    rd_ok  = 1'b0;
    case (ple_pkg::kind_t'(kind))
      ple_pkg::KIND_INSERT: begin
        if (len_ext == ple_pkg::CMP_W'(ple_pkg::DEPTH)) begin
          st = ple_pkg::ST_FULL;
        end else if (pos_ext == '0 || pos_ext > len_ext + ple_pkg::CMP_W'(1)) begin
          st = ple_pkg::ST_BADPOS;
        end else begin
          st     = ple_pkg::ST_OK;
          ins_ok = 1'b1;
        end
      end
      ple_pkg::KIND_DELETE, ple_pkg::KIND_READ: begin
        if (length == '0) begin
          st = ple_pkg::ST_EMPTY;
        end else if (pos_ext == '0 || pos_ext > len_ext) begin
          st = ple_pkg::ST_BADPOS;
        end else begin
          st = ple_pkg::ST_OK;
          if (ple_pkg::kind_t'(kind) == ple_pkg::KIND_READ) begin
            rd_ok = 1'b1;
          end else begin
            del_ok = 1'b1;
          end
        end
      end
      default: begin
        st = ple_pkg::ST_BADPOS;
      end
    endcase
  end

  // chain command, only for a request that changes the list
  assign cmd.ins = start & ins_ok;
  assign cmd.del = start & del_ok;
  assign cmd.idx = idx;

  // read word, gated so a bad index never reaches the result
  assign rd_word = rd_ok ? cells_q[idx] : '0;

  always_comb begin
    length_next = length;
    if (cmd.ins) begin
      length_next = length + ple_pkg::LEN_W'(1);
    end else if (cmd.del) begin
      length_next = length - ple_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
      done   <= 1'b0;
    end else begin
      length <= length_next;
      done   <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      status_q <= st;
      data_out <= 32'(rd_word);
      count    <= 5'(length_next);
    end
  end

  assign status = status_q;

  `PLE_ASSERT(a_len_bound, clk, rst, length <= ple_pkg::LEN_W'(ple_pkg::DEPTH))
  `PLE_ASSERT(a_done_after_req, clk, rst, (start && !$past(rst)) |=> done)
  `PLE_ASSERT(a_ins_grows, clk, rst, cmd.ins |=> length == $past(length) + ple_pkg::LEN_W'(1))
  `PLE_ASSERT(a_err_no_data, clk, rst, (done && status_q != ple_pkg::ST_OK) |-> data_out == '0)
  `PLE_ASSERT_RST(a_rst_quiet, clk, rst |=> (!done && length == '0))

endmodule
